### hw/rtl/orle_pkg.sv
package orle_pkg;

    typedef enum logic [2:0] {
        MODE_INS_POS = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_INS_TAIL = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_DEL_POS = 3'd4,
        MODE_DEL_MATCH = 3'd5
    } t_mode;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_WALK = 8'b00000010,
        S_WREAD = 8'b00000100,
        S_DECIDE = 8'b00001000,
        S_LINK = 8'b00010000,
        S_LINK2 = 8'b00100000,
        S_DONE = 8'b01000000,
        S_FREE = 8'b10000000
    } t_state;

endpackage

### hw/rtl/ordered_record_list_engine.sv
// Channel | Dir | tdata fields (low bit up)               | tuser
// s_axis  | in  | mode[2:0] position[9:3] age amount        | -
// m_axis  | out | status[1:0] found_position length         | -
// Flow: modes 6/7 go straight from S_IDLE to S_DONE; rejected requests (full,
// range, search on an empty list) go from S_DECIDE to S_DONE; insert at head or tail
// reads one node only (the tail comes from the last-node register). Positional and
// match requests walk the list with one registered read of the link/record memories
// per node (S_WALK, then S_WREAD).
// Reset: synchronous active low; the free stack fills by a clearing pass over all
// CAPACITY entries after reset, during which s_axis_tready stays low.
// Stalls: one request at a time; a result holds in the output register until
// taken. The next word is accepted meanwhile, and its result waits in S_DONE
// until the output register is free.
module ordered_record_list_engine
    import orle_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int FIELD_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // mode, position, age, amount, zero fill
    input  logic [((3 + $clog2(CAPACITY) + 1 + 2 * FIELD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, found_position, length, zero fill
    output logic [((2 + 2 * $clog2(CAPACITY) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = IW + 1;
    localparam int OW = ((2 + IW + CW + 7) / 8) * 8;
    localparam int RO = 3 + CW;     // first record field offset in tdata
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // memories
    logic [FIELD_WIDTH-1:0] m_age [CAPACITY];
    logic [FIELD_WIDTH-1:0] m_amt [CAPACITY];
    logic [IW-1:0] m_link [CAPACITY];
    logic [IW-1:0] m_free [CAPACITY];

    t_state r_state, n_state;
    logic [CW-1:0] r_count, r_ftop, r_i, r_target;
    logic [IW-1:0] r_first, r_last, r_node, r_prev, r_new;
    logic [2:0] r_mode;
    logic [FIELD_WIDTH-1:0] r_a, r_v, r_ra, r_rv;
    logic [IW-1:0] r_rlink, r_rfree;
    logic r_fill;
    logic [CW-1:0] r_fidx;
    logic [1:0] r_stat;
    logic [IW-1:0] r_found;
    logic r_ovalid;
    logic [1:0] r_ostat;
    logic [IW-1:0] r_ofound;
    logic [CW-1:0] r_olen;
    logic w_match;

    // memory write port controls
    logic w_rec_we, w_link_we, w_free_we;
    logic [IW-1:0] w_link_addr, w_link_data, w_free_addr, w_free_data, w_rd_addr;

    assign s_axis_tready = r_state == S_IDLE && !r_fill;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = OW'({r_olen, r_ofound, r_ostat});

    always_ff @(posedge i_clk) begin
        if (w_rec_we) begin
            m_age[r_new] <= r_a;
            m_amt[r_new] <= r_v;
        end
        if (w_link_we) m_link[w_link_addr] <= w_link_data;
        if (w_free_we) m_free[w_free_addr] <= w_free_data;
        r_ra <= m_age[w_rd_addr];
        r_rv <= m_amt[w_rd_addr];
        r_rlink <= m_link[w_rd_addr];
        r_rfree <= m_free[IW'(r_ftop - 1'b1)];
    end

    logic w_ins, w_del, w_search;
    assign w_ins = r_mode == MODE_INS_POS || r_mode == MODE_INS_HEAD
                   || r_mode == MODE_INS_TAIL;
    assign w_del = r_mode == MODE_DEL_POS;
    assign w_search = r_mode == MODE_SEARCH || r_mode == MODE_DEL_MATCH;
    assign w_match = r_ra == r_a && r_rv == r_v;
    assign w_rd_addr = r_node;

    always_comb begin
        n_state = r_state;
        w_rec_we = 1'b0;
        w_link_we = 1'b0;
        w_free_we = r_fill;
        w_free_addr = IW'(r_fidx);
        w_free_data = IW'(r_fidx);
        w_link_addr = r_new;
        w_link_data = r_node;
        case (r_state)
            S_LINK: begin
                if (w_ins) begin
                    w_rec_we = 1'b1;
                    w_link_we = 1'b1;
                    w_link_addr = r_new;
                    // new node points to successor (r_first at position 0, else the walked node's link r_rlink)
                    w_link_data = (r_target == '0 && r_count == '0) ? '0 :
                                  (r_target == '0 ? r_first : r_rlink);
                end else begin
                    // unlink: prev.next = node.next
                    w_link_we = r_target != '0;
                    w_link_addr = r_prev;
                    w_link_data = r_rlink;
                end
            end
            S_LINK2: begin
                if (w_ins) begin
                    w_link_we = r_target != '0;
                    w_link_addr = r_prev;
                    w_link_data = r_new;
                end else begin
                    w_free_we = 1'b1;
                    w_free_addr = IW'(r_ftop);
                    w_free_data = r_node;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= 1'b1;
            r_fidx <= '0;
            r_ftop <= CAP;
            r_count <= '0;
            r_first <= '0;
            r_last <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_fill) begin
                r_fidx <= r_fidx + 1'b1;
                if (r_fidx == CAP - 1'b1) r_fill <= 1'b0;
            end
            if (r_ovalid && m_axis_tready && r_state != S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_mode <= s_axis_tdata[2:0];
                        r_a <= s_axis_tdata[RO +: FIELD_WIDTH];
                        r_v <= s_axis_tdata[RO + FIELD_WIDTH +: FIELD_WIDTH];
                        r_found <= '0;
                        r_stat <= ST_OK;
                        r_i <= '0;
                        r_node <= r_first;
                        r_prev <= r_first;
                        case (s_axis_tdata[2:0])
                            MODE_INS_HEAD: r_target <= '0;
                            MODE_INS_TAIL: r_target <= r_count;
                            default: r_target <= s_axis_tdata[3 +: CW];
                        endcase
                        if (s_axis_tdata[2:0] > MODE_DEL_MATCH) r_state <= S_DONE;
                        else r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    // checks, then start a walk
                    if (w_ins) begin
                        if (r_count >= CAP) begin
                            r_stat <= ST_FULL; r_state <= S_DONE;
                        end else if (r_target > r_count) begin
                            r_stat <= ST_RANGE; r_state <= S_DONE;
                        end else begin
                            r_new <= r_rfree;
                            r_ftop <= r_ftop - 1'b1;
                            // append: start on the last node, one read only
                            if (r_target == r_count && r_count != '0) begin
                                r_node <= r_last;
                                r_i <= r_count - 1'b1;
                            end
                            r_state <= S_WALK;
                        end
                    end else if (w_del) begin
                        if (CW'(r_target) >= r_count) begin
                            r_stat <= ST_RANGE; r_state <= S_DONE;
                        end else r_state <= S_WALK;
                    end else begin
                        if (r_count == '0) begin
                            r_stat <= ST_NOMATCH; r_state <= S_DONE;
                        end else r_state <= S_WALK;
                    end
                end
                S_WALK: r_state <= S_WREAD; // memory read of r_node in flight
                S_WREAD: begin
                    if (w_search) begin
                        if (w_match) begin
                            if (r_mode == MODE_SEARCH) begin
                                r_found <= IW'(r_i);
                                r_state <= S_DONE;
                            end else begin
                                r_target <= r_i;
                                r_state <= S_LINK;
                            end
                        end else if (r_i + 1'b1 == r_count) begin
                            r_stat <= ST_NOMATCH; r_state <= S_DONE;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_prev <= r_node;
                            r_node <= r_rlink;
                            r_state <= S_WALK;
                        end
                    end else if (w_ins ? (r_target == '0 || r_i + 1'b1 == r_target)
                                       : r_i == r_target) begin
                        r_state <= S_LINK;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_prev <= r_node;
                        r_node <= r_rlink;
                        r_state <= S_WALK;
                    end
                end
                S_LINK: begin
                    if (w_ins) begin
                        if (r_target == '0) r_first <= r_new;
                        if (r_target == r_count) r_last <= r_new;
                        r_prev <= r_node;
                    end else begin
                        if (r_target == '0) r_first <= r_rlink;
                        else if (r_target == r_count - 1'b1) r_last <= r_prev;
                    end
                    r_state <= S_LINK2;
                end
                S_LINK2: begin
                    if (w_ins) r_count <= r_count + 1'b1;
                    else begin
                        r_count <= r_count - 1'b1;
                        r_ftop <= r_ftop + 1'b1;
                        if (r_count == CW'(1)) begin
                            r_first <= '0; r_last <= '0;
                        end
                    end
                    r_state <= S_FREE;
                end
                S_FREE: r_state <= S_DONE;
                S_DONE: begin
                    // wait here while the previous result is still held
                    if (!r_ovalid || m_axis_tready) begin
                        r_ostat <= r_stat;
                        r_ofound <= r_found;
                        r_olen <= r_count;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // insert at pos>0: walk stops on prev (pos-1); r_prev<=r_node in LINK so
    // LINK2 writes prev.next. Position 0 skips the link patch.

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP) else $error("count over capacity");
    a_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_count + r_ftop == CAP) else $error("pool leak");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while held");
endmodule
